// File: design/sdof_pkg.sv
// ----------------------------------------------------------------------------
// sdof_pkg: shared types and constants for the six-axis report decoder
// Line length limits, report and error codes, nibble-code check, result type.
// ----------------------------------------------------------------------------
package sdof_pkg;

  localparam int LINE_BYTES_DEF = 32;
  localparam int HEAD_BYTES     = 25;
  localparam int AXIS_LINE_LEN  = 25;
  localparam int KEY_LINE_LEN   = 4;
  localparam int NUM_AXES       = 6;

  localparam logic [7:0] CR_BYTE     = 8'h0D;
  localparam logic [7:0] CH_ERR      = 8'h65;
  localparam logic [7:0] CH_AXIS     = 8'h64;
  localparam logic [7:0] CH_KEY      = 8'h6B;
  localparam logic [7:0] ERR_CODE_CMD   = 8'h01;
  localparam logic [7:0] ERR_CODE_FRAME = 8'h02;
  localparam logic [15:0] AXIS_BIAS  = 16'h8000;
  localparam logic [15:0] TALLY_MAX  = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_AXIS = 2'd0,
    KIND_KEY  = 2'd1,
    KIND_ERR  = 2'd2
  } report_kind_t;

  typedef enum logic [1:0] {
    ERR_ILLEGAL = 2'd0,
    ERR_FRAMING = 2'd1,
    ERR_OTHER   = 2'd2
  } error_kind_t;

  typedef struct packed {
    logic [HEAD_BYTES-1:0][7:0] head;
    logic                       len_zero;
    logic                       len_ge2;
    logic                       len_axis;
    logic                       len_key;
  } line_state_t;

  typedef struct packed {
    report_kind_t              kind;
    logic [NUM_AXES-1:0][15:0] axis;
    logic [11:0]               buttons;
    error_kind_t               err_kind;
    logic [15:0]               errors_seen;
  } result_t;

  function automatic logic nib_ok(input logic [7:0] c);
    logic [7:0] code;
    unique case (c[3:0])
      4'h0: code = 8'h30;
      4'h1: code = 8'h41;
      4'h2: code = 8'h42;
      4'h3: code = 8'h33;
      4'h4: code = 8'h44;
      4'h5: code = 8'h35;
      4'h6: code = 8'h36;
      4'h7: code = 8'h47;
      4'h8: code = 8'h48;
      4'h9: code = 8'h39;
      4'hA: code = 8'h3A;
      4'hB: code = 8'h4B;
      4'hC: code = 8'h3C;
      4'hD: code = 8'h4D;
      4'hE: code = 8'h4E;
      4'hF: code = 8'h3F;
      default: code = 8'h00;
    endcase
    return c == code;
  endfunction

endpackage

// File: design/sdof_line.sv
// ----------------------------------------------------------------------------
// sdof_line: line collector
// Gathers bytes of the current line, tracks length and overflow, clears on CR.
// ----------------------------------------------------------------------------
module sdof_line #(
  parameter int LINE_BYTES = sdof_pkg::LINE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr,
  input  logic [7:0]           rx_byte,
  output sdof_pkg::line_state_t line
);
  import sdof_pkg::*;

  localparam int CNT_W = $clog2(LINE_BYTES + 1);

  logic [HEAD_BYTES-1:0][7:0] head_r;
  logic [CNT_W-1:0]           count_r;
  logic                       ovf_r;
  logic                       is_cr;
  logic                       full;

  assign is_cr = rx_byte == CR_BYTE;
  assign full  = count_r == CNT_W'(LINE_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (wr) begin
      if (is_cr) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (full) begin
        ovf_r <= 1'b1;
      end else begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HEAD_BYTES; i++) begin
      if (wr && !is_cr && count_r == CNT_W'(i)) begin
        head_r[i] <= rx_byte;
      end
    end
  end

  assign line.head     = head_r;
  assign line.len_zero = ovf_r || count_r == '0;
  assign line.len_ge2  = count_r >= CNT_W'(2);
  assign line.len_axis = !ovf_r && count_r == CNT_W'(AXIS_LINE_LEN);
  assign line.len_key  = !ovf_r && count_r == CNT_W'(KEY_LINE_LEN);

endmodule

// File: design/sdof_dec.sv
// ----------------------------------------------------------------------------
// sdof_dec: line-end decoder
// Classifies a finished line and forms the report and the next error tally.
// ----------------------------------------------------------------------------
module sdof_dec (
  input  sdof_pkg::line_state_t line,
  input  logic                  decode_en,
  input  logic [15:0]           tally,
  output logic                  fire,
  output logic                  is_err,
  output logic [15:0]           tally_nxt,
  output sdof_pkg::result_t     res
);
  import sdof_pkg::*;

  logic                      axis_ok;
  logic                      key_ok;
  logic [NUM_AXES-1:0][15:0] raw;

  always_comb begin
    axis_ok = 1'b1;
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < 4; j++) begin
        axis_ok = axis_ok & nib_ok(line.head[1 + 4 * i + j]);
        raw[i][15 - 4 * j -: 4] = line.head[1 + 4 * i + j][3:0];
      end
    end
  end

  assign key_ok = nib_ok(line.head[1]) && nib_ok(line.head[2]) && nib_ok(line.head[3]);

  assign is_err    = !line.len_zero && line.head[0] == CH_ERR;
  assign tally_nxt = (tally == TALLY_MAX) ? tally : tally + 16'd1;

  always_comb begin
    fire = 1'b0;
    res  = '0;
    res.errors_seen = tally;
    if (is_err) begin
      fire            = 1'b1;
      res.kind        = KIND_ERR;
      res.errors_seen = tally_nxt;
      if (line.len_ge2 && line.head[1] == ERR_CODE_CMD) begin
        res.err_kind = ERR_ILLEGAL;
      end else if (line.len_ge2 && line.head[1] == ERR_CODE_FRAME) begin
        res.err_kind = ERR_FRAMING;
      end else begin
        res.err_kind = ERR_OTHER;
      end
    end else if (decode_en && line.head[0] == CH_AXIS && line.len_axis && axis_ok) begin
      fire     = 1'b1;
      res.kind = KIND_AXIS;
      for (int i = 0; i < NUM_AXES; i++) begin
        res.axis[i] = raw[i] ^ AXIS_BIAS;
      end
    end else if (decode_en && line.head[0] == CH_KEY && line.len_key && key_ok) begin
      fire        = 1'b1;
      res.kind    = KIND_KEY;
      res.buttons = {line.head[3][3:0], line.head[2][3:0], line.head[1][3:0]};
    end
  end

endmodule

// File: design/sixdof_serial_report_decoder_unit.sv
// ----------------------------------------------------------------------------
// sixdof_serial_report_decoder_unit: six-axis serial report decoder
// Collects serial bytes into lines and decodes axis, button and error reports.
// ----------------------------------------------------------------------------
// Output: a report is registered and appears in the cycle after its CR byte is taken.
// Throughput: one byte per cycle; the output register stalls input only while
// a report waits and out_ready is low.
// Reset: synchronous active-low rst_n clears line length, overflow, error tally
// and output valid, and sets decode enable to 1; line bytes are not cleared.
module sixdof_serial_report_decoder_unit #(
  parameter int LINE_BYTES = sdof_pkg::LINE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_report_kind,
  output logic signed [15:0] out_axis_x,
  output logic signed [15:0] out_axis_y,
  output logic signed [15:0] out_axis_z,
  output logic signed [15:0] out_axis_rx,
  output logic signed [15:0] out_axis_ry,
  output logic signed [15:0] out_axis_rz,
  output logic [11:0]        out_buttons,
  output logic [1:0]         out_error_kind,
  output logic [15:0]        out_errors_seen
);
  import sdof_pkg::*;

  logic        decode_en_r;
  logic [15:0] tally_r;
  logic        out_valid_r;
  result_t     res_r;

  line_state_t line;
  logic        accept;
  logic        eol;
  logic        fire;
  logic        is_err;
  logic [15:0] tally_nxt;
  result_t     res;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign eol      = accept && in_rx_byte == CR_BYTE;

  sdof_line #(
    .LINE_BYTES(LINE_BYTES)
  ) u_line (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (accept),
    .rx_byte(in_rx_byte),
    .line   (line)
  );

  sdof_dec u_dec (
    .line     (line),
    .decode_en(decode_en_r),
    .tally    (tally_r),
    .fire     (fire),
    .is_err   (is_err),
    .tally_nxt(tally_nxt),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_en_r <= 1'b1;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        decode_en_r <= cfg_wdata;
      end
      if (eol && is_err) begin
        tally_r <= tally_nxt;
      end
      if (eol && fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eol && fire) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_report_kind = res_r.kind;
  assign out_axis_x      = $signed(res_r.axis[0]);
  assign out_axis_y      = $signed(res_r.axis[1]);
  assign out_axis_z      = $signed(res_r.axis[2]);
  assign out_axis_rx     = $signed(res_r.axis[3]);
  assign out_axis_ry     = $signed(res_r.axis[4]);
  assign out_axis_rz     = $signed(res_r.axis[5]);
  assign out_buttons     = res_r.buttons;
  assign out_error_kind  = res_r.err_kind;
  assign out_errors_seen = res_r.errors_seen;

endmodule

// File: tb/sixdof_serial_report_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sixdof_serial_report_decoder_unit_tb: line decoder testbench
// Streams serial bytes through the decoder with random idle on both channels.
// A predictor tracks the line buffer, error tally and decode enable, and each
// report is compared field by field. The run covers directed lines, random
// well-formed and broken lines under both decode settings, a long receiver
// hold-off, and a stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module sixdof_serial_report_decoder_unit_tb;
  import sdof_pkg::*;

  localparam int LINE_BYTES = sdof_pkg::LINE_BYTES_DEF;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic               cfg_wdata  = 1'b0;
  logic               in_valid   = 1'b0;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_ready  = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [1:0]         out_report_kind;
  logic signed [15:0] out_axis_x;
  logic signed [15:0] out_axis_y;
  logic signed [15:0] out_axis_z;
  logic signed [15:0] out_axis_rx;
  logic signed [15:0] out_axis_ry;
  logic signed [15:0] out_axis_rz;
  logic [11:0]        out_buttons;
  logic [1:0]         out_error_kind;
  logic [15:0]        out_errors_seen;

  logic [7:0] byte_q[$];
  result_t    report_q[$];
  int         bytes_sent  = 0;
  int         bytes_taken = 0;
  int         bytes_queued = 0;
  int         mismatches  = 0;
  bit         quiet       = 1'b0;

  logic [7:0]  line_buf [LINE_BYTES];
  int          line_len  = 0;
  bit          line_ovf  = 1'b0;
  logic [15:0] err_tally = 16'h0000;
  bit          dec_en    = 1'b1;

  logic [7:0] nib_char [16] = '{
    8'h30, 8'h41, 8'h42, 8'h33, 8'h44, 8'h35, 8'h36, 8'h47,
    8'h48, 8'h39, 8'h3A, 8'h4B, 8'h3C, 8'h4D, 8'h4E, 8'h3F
  };

  int tx_gap    = 0;
  int tx_burst  = 0;
  int rx_gap    = 0;
  int rx_burst  = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  sixdof_serial_report_decoder_unit #(
    .LINE_BYTES(LINE_BYTES)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_report_kind(out_report_kind),
    .out_axis_x     (out_axis_x),
    .out_axis_y     (out_axis_y),
    .out_axis_z     (out_axis_z),
    .out_axis_rx    (out_axis_rx),
    .out_axis_ry    (out_axis_ry),
    .out_axis_rz    (out_axis_rz),
    .out_buttons    (out_buttons),
    .out_error_kind (out_error_kind),
    .out_errors_seen(out_errors_seen)
  );

  always #10 clk = ~clk;

  function automatic bit nib_valid(input logic [7:0] c);
    return c == nib_char[c[3:0]];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CR_BYTE) ? 8'h7F : b;
  endfunction

  function automatic logic [15:0] pick_code();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    result_t     want;
    int          len, i, j;
    logic [15:0] v;
    bit          ok;
    if (b == CR_BYTE) begin
      len  = line_ovf ? 0 : line_len;
      want = '0;
      if (len != 0) begin
        if (line_buf[0] == CH_ERR) begin
          if (err_tally != TALLY_MAX) err_tally++;
          want.kind = KIND_ERR;
          if (len >= 2 && line_buf[1] == ERR_CODE_CMD) begin
            want.err_kind = ERR_ILLEGAL;
          end else if (len >= 2 && line_buf[1] == ERR_CODE_FRAME) begin
            want.err_kind = ERR_FRAMING;
          end else begin
            want.err_kind = ERR_OTHER;
          end
          want.errors_seen = err_tally;
          report_q.push_back(want);
        end else if (dec_en) begin
          if (line_buf[0] == CH_AXIS && len == AXIS_LINE_LEN) begin
            ok = 1'b1;
            for (i = 0; i < NUM_AXES; i++) begin
              v = 16'h0000;
              for (j = 0; j < 4; j++) begin
                if (!nib_valid(line_buf[1 + 4 * i + j])) ok = 1'b0;
                v = {v[11:0], line_buf[1 + 4 * i + j][3:0]};
              end
              want.axis[i] = v ^ AXIS_BIAS;
            end
            if (ok) begin
              want.kind        = KIND_AXIS;
              want.errors_seen = err_tally;
              report_q.push_back(want);
            end
          end else if (line_buf[0] == CH_KEY && len == KEY_LINE_LEN) begin
            if (nib_valid(line_buf[1]) && nib_valid(line_buf[2]) && nib_valid(line_buf[3])) begin
              want.kind        = KIND_KEY;
              want.buttons     = {line_buf[3][3:0], line_buf[2][3:0], line_buf[1][3:0]};
              want.errors_seen = err_tally;
              report_q.push_back(want);
            end
          end
        end
      end
      line_len = 0;
      line_ovf = 1'b0;
    end else if (line_len < LINE_BYTES) begin
      line_buf[line_len] = b;
      line_len++;
    end else begin
      line_ovf = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input longint expv, input longint actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
      mismatches++;
    end
  endtask

  task automatic check_report();
    result_t want, got;
    int      i;
    got.kind        = report_kind_t'(out_report_kind);
    got.axis[0]     = out_axis_x;
    got.axis[1]     = out_axis_y;
    got.axis[2]     = out_axis_z;
    got.axis[3]     = out_axis_rx;
    got.axis[4]     = out_axis_ry;
    got.axis[5]     = out_axis_rz;
    got.buttons     = out_buttons;
    got.err_kind    = error_kind_t'(out_error_kind);
    got.errors_seen = out_errors_seen;
    if (report_q.size() == 0) begin
      $display("%0t: unexpected report, expected none actual kind %0d", $time, out_report_kind);
      mismatches++;
    end else begin
      want = report_q.pop_front();
      check_field("report_kind", want.kind, got.kind);
      for (i = 0; i < NUM_AXES; i++) begin
        check_field($sformatf("axis %0d", i), $signed(want.axis[i]), $signed(got.axis[i]));
      end
      check_field("buttons", want.buttons, got.buttons);
      check_field("error_kind", want.err_kind, got.err_kind);
      check_field("errors_seen", want.errors_seen, got.errors_seen);
    end
  endtask

  // sender: hold the request until taken, then idle or advance
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (bytes_sent != bytes_taken) begin
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_valid <= 1'b0;
    end else if (byte_q.size() != 0) begin
      in_rx_byte <= byte_q.pop_front();
      in_valid   <= 1'b1;
      bytes_sent++;
      if (quiet || tx_burst > 0) begin
        tx_gap = 0;
        if (tx_burst > 0) tx_burst--;
      end else begin
        tx_gap = pick_gap();
        if ($urandom_range(0, 63) == 0) tx_burst = $urandom_range(20, 120);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random stalls, one long hold-off once traffic is flowing
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && bytes_taken >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_ready <= 1'b0;
    end else if (quiet || rx_burst > 0) begin
      if (rx_burst > 0) rx_burst--;
      out_ready <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      rx_gap = pick_gap();
      if ($urandom_range(0, 63) == 0) rx_burst = $urandom_range(20, 120);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        bytes_taken++;
        decode_byte(in_rx_byte);
      end
      if (out_valid && out_ready) check_report();
    end
  end

  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_axis_line(input logic [5:0][15:0] codes, input int mode);
    int i, j, base;
    base = byte_q.size();
    push_byte(CH_AXIS);
    for (i = 0; i < NUM_AXES; i++) begin
      for (j = 3; j >= 0; j--) begin
        if (!(mode == 2 && i == NUM_AXES - 1 && j == 0)) push_byte(nib_char[codes[i][4 * j +: 4]]);
      end
    end
    if (mode == 3) push_byte(nib_char[4'($urandom_range(0, 15))]);
    if (mode == 1) byte_q[base + $urandom_range(1, 24)] = junk_byte();
    push_byte(CR_BYTE);
  endtask

  task automatic push_key_line(input logic [11:0] keys, input int mode);
    int base;
    base = byte_q.size();
    push_byte(CH_KEY);
    push_byte(nib_char[keys[3:0]]);
    push_byte(nib_char[keys[7:4]]);
    if (mode != 2) push_byte(nib_char[keys[11:8]]);
    if (mode == 3) push_byte(nib_char[4'($urandom_range(0, 15))]);
    if (mode == 1) byte_q[base + $urandom_range(1, 3)] = junk_byte();
    push_byte(CR_BYTE);
  endtask

  task automatic push_err_line(input int code_sel, input int tail);
    int i;
    push_byte(CH_ERR);
    case (code_sel)
      1: push_byte(ERR_CODE_CMD);
      2: push_byte(ERR_CODE_FRAME);
      3: push_byte(junk_byte());
      default: ;
    endcase
    for (i = 0; i < tail; i++) push_byte(junk_byte());
    push_byte(CR_BYTE);
  endtask

  // lengths from the buffer size up, so both the full and the overflowed line occur
  task automatic push_long_line();
    int i, total, lead;
    total = LINE_BYTES + $urandom_range(0, 8);
    lead  = $urandom_range(0, 3);
    push_byte(lead == 0 ? CH_ERR : lead == 1 ? CH_AXIS : lead == 2 ? CH_KEY : junk_byte());
    for (i = 1; i < total; i++) push_byte(nib_char[4'($urandom_range(0, 15))]);
    push_byte(CR_BYTE);
  endtask

  task automatic push_noise_line();
    int i, n;
    n = $urandom_range(0, 40);
    for (i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
    push_byte(CR_BYTE);
  endtask

  task automatic push_random_line();
    int          sel, i;
    logic [5:0][15:0] codes;
    logic [11:0] keys;
    for (i = 0; i < NUM_AXES; i++) codes[i] = pick_code();
    keys = ($urandom_range(0, 7) == 0) ? 12'hFFF : 12'($urandom_range(0, 4095));
    sel  = $urandom_range(0, 99);
    if (sel < 30) begin
      push_axis_line(codes, 0);
    end else if (sel < 38) begin
      push_axis_line(codes, $urandom_range(1, 3));
    end else if (sel < 53) begin
      push_key_line(keys, 0);
    end else if (sel < 59) begin
      push_key_line(keys, $urandom_range(1, 3));
    end else if (sel < 74) begin
      push_err_line($urandom_range(0, 3), $urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
    end else if (sel < 81) begin
      push_long_line();
    end else if (sel < 86) begin
      push_byte(CR_BYTE);
    end else begin
      push_noise_line();
    end
  endtask

  task automatic run_random(input int n);
    int stop_at;
    stop_at = bytes_queued + n;
    while (bytes_queued < stop_at) push_random_line();
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || bytes_sent != bytes_taken || report_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic set_decode(input bit en);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    dec_en     = en;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    set_decode(1'b1);

    push_byte(CR_BYTE);
    push_err_line(0, 0);
    push_err_line(1, 0);
    push_err_line(2, 0);
    push_key_line(12'hFFF, 0);
    push_key_line(12'h000, 0);
    push_axis_line({16'h5A3C, 16'h8001, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000}, 0);
    drain();

    set_decode(1'b0);
    run_random(330);
    drain();
    set_decode(1'b1);
    run_random(680);
    drain();
    set_decode(1'b0);
    run_random(140);
    drain();
    set_decode(1'b1);
    quiet = 1'b1;
    run_random(240);
    drain();
    quiet = 1'b0;

    repeat (10) @(negedge clk);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
